// File: rtl/packet_fragment_framer_core_assert.svh
// assertion macros shared by the framer checker
// no dependencies; included by the checker file
`ifndef PACKET_FRAGMENT_FRAMER_CORE_ASSERT_SVH
`define PACKET_FRAGMENT_FRAMER_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define PFF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("framer check failed");

// next-cycle implication, disabled during reset
`define PFF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("framer check failed");

`endif

// File: rtl/pff_pkg.sv
// shared widths, constants and types of the packet fragment framer
// no dependencies; used by pff_divider, packet_fragment_framer_core and pff_checker
`timescale 1ns / 1ps

package pff_pkg;

    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 16;
    localparam int FSZ_W     = 11;
    localparam int WORD_W    = 32;
    localparam int FBYTES_W  = 12;
    localparam int ASM_W     = 24;

    // dividend is length + step - 1, one bit wider than the length
    localparam int DVD_W     = LEN_W + 1;
    localparam int DIV_STEPS = DVD_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [FSZ_W-1:0]    FRAG_SIZE_RESET = FSZ_W'(2 * 1024 - 100);
    localparam logic [FSZ_W-1:0]    FRAG_SIZE_MIN   = FSZ_W'(4);
    localparam logic [FBYTES_W-1:0] BUFFER_BYTES    = FBYTES_W'(2048);
    localparam logic [FBYTES_W-1:0] TRAILER_BYTES   = FBYTES_W'(4);

    // register index of fragment_size
    localparam logic [0:0] REG_FRAG_SIZE = 1'b0;

    // sequencer states, one-hot
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_PROC = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    // divider handshake toward the sequencer
    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
    } t_div_status;

    // pad bytes to the next word boundary
    function automatic logic [1:0] pad_bytes(input logic [1:0] len_lsb);
        pad_bytes = 2'd0 - len_lsb;
    endfunction

endpackage

// File: rtl/pff_divider.sv
// restoring divider, one quotient bit per cycle
// depends on pff_pkg
`timescale 1ns / 1ps

module pff_divider (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [pff_pkg::DVD_W-1:0]   i_dividend,
    input  logic [pff_pkg::FSZ_W-1:0]   i_divisor,
    output pff_pkg::t_div_status        o_status
);

    logic [pff_pkg::DVD_W-1:0]     r_quo, n_quo;
    logic [pff_pkg::FSZ_W-1:0]     r_rem, n_rem;
    logic [pff_pkg::FSZ_W-1:0]     r_dvs, n_dvs;
    logic [pff_pkg::DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic                          r_busy, n_busy;
    logic                          r_done, n_done;
    logic [pff_pkg::FSZ_W:0]       trial;
    logic [pff_pkg::FSZ_W:0]       diff;
    logic                          fits;

    // one shift-subtract step
    always_comb begin
        trial = {r_rem, r_quo[pff_pkg::DVD_W-1]};
        diff  = trial - {1'b0, r_dvs};
        fits  = trial >= {1'b0, r_dvs};
    end

    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_quo  = i_dividend;
            n_rem  = '0;
            n_dvs  = i_divisor;
            n_cnt  = pff_pkg::DIV_CNT_W'(pff_pkg::DIV_STEPS - 1);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_quo = {r_quo[pff_pkg::DVD_W-2:0], fits};
            n_rem = fits ? diff[pff_pkg::FSZ_W-1:0] : trial[pff_pkg::FSZ_W-1:0];
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 1'b1;
            end
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_status.done     = r_done;
    assign o_status.quotient = r_quo;

endmodule

// File: rtl/packet_fragment_framer_core.sv
// Packet fragment framer: cuts a byte stream into framed 32-bit word fragments.
// Flow: one byte at a time; o_ready is high only in S_IDLE, so a new byte is not taken
//   until the last one has passed S_PROC and sent its words from S_EMIT, where i_ready can stall.
//   A packet's first byte passes S_DIV first, while the bit-serial fragment-count divider
//   runs its 17 steps.
// Reset: synchronous active-low; idle between packets, fragment_size back to 1948.
`timescale 1ns / 1ps

module packet_fragment_framer_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input byte channel
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [pff_pkg::BYTE_W-1:0]     i_data_byte,
    input  logic [pff_pkg::LEN_W-1:0]      i_packet_length,
    // output word channel
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [pff_pkg::WORD_W-1:0]     o_out_word,
    output logic                           o_is_trailer,
    output logic [pff_pkg::FBYTES_W-1:0]   o_fragment_bytes,
    output logic                           o_packet_done,
    // configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [1:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    pff_pkg::t_state                  r_state, n_state;
    logic [pff_pkg::FSZ_W-1:0]        r_frag_size, n_frag_size;
    logic [pff_pkg::FSZ_W-1:0]        r_step, n_step;
    logic [pff_pkg::LEN_W-1:0]        r_left, n_left;
    logic [pff_pkg::FSZ_W-1:0]        r_taken, n_taken;
    logic [7:0]                       r_num, n_num;
    logic [7:0]                       r_total, n_total;
    logic [pff_pkg::ASM_W-1:0]        r_asm, n_asm;
    logic [1:0]                       r_lane, n_lane;
    logic                             r_drop_pkt, n_drop_pkt;
    logic                             r_drop_frag, n_drop_frag;
    logic                             r_has_w, n_has_w;
    logic                             r_has_t, n_has_t;
    logic                             r_ovalid, n_ovalid;
    logic [pff_pkg::BYTE_W-1:0]       r_byte, n_byte;
    logic [pff_pkg::WORD_W-1:0]       r_pw, n_pw;
    logic [pff_pkg::WORD_W-1:0]       r_pt, n_pt;
    logic [pff_pkg::FBYTES_W-1:0]     r_pbytes, n_pbytes;
    logic                             r_pdone, n_pdone;
    logic [pff_pkg::WORD_W-1:0]       r_oword, n_oword;
    logic                             r_otrl, n_otrl;
    logic [pff_pkg::FBYTES_W-1:0]     r_obytes, n_obytes;
    logic                             r_odone, n_odone;

    logic                             in_acc;
    logic                             cfg_wr;
    logic                             out_free;
    logic [pff_pkg::FSZ_W-1:0]        step_v;
    logic [pff_pkg::DVD_W-1:0]        dividend;
    logic                             div_start;
    pff_pkg::t_div_status             div_st;

    // per-byte datapath
    logic                             first;
    logic [pff_pkg::FSZ_W-1:0]        flen_first;
    logic [pff_pkg::FBYTES_W-1:0]     slen_first;
    logic                             drop_frag_v;
    logic                             quiet;
    logic [7:0]                       num_v;
    logic [pff_pkg::ASM_W-1:0]        asm_v;
    logic [pff_pkg::ASM_W-1:0]        asm_ins;
    logic [1:0]                       lane_v;
    logic                             full;
    logic [pff_pkg::FSZ_W-1:0]        taken_n;
    logic [pff_pkg::LEN_W-1:0]        left_n;
    logic                             frag_end;
    logic [1:0]                       pad;
    logic [pff_pkg::ASM_W-1:0]        asm_after;
    logic [1:0]                       lane_after;
    logic                             emit_w;
    logic                             emit_t;

    assign o_ready  = (r_state == pff_pkg::S_IDLE);
    assign in_acc   = i_valid && o_ready;
    assign out_free = !r_ovalid || i_ready;
    assign cfg_wr   = psel && penable && pwrite && (paddr[1:1] == pff_pkg::REG_FRAG_SIZE);

    // fragment step, at least four bytes
    assign step_v   = (r_frag_size < pff_pkg::FRAG_SIZE_MIN) ? pff_pkg::FRAG_SIZE_MIN
                                                             : r_frag_size;
    assign dividend = pff_pkg::DVD_W'(i_packet_length) + pff_pkg::DVD_W'(step_v)
                    - pff_pkg::DVD_W'(1);
    assign div_start = in_acc && (r_left == '0) && (i_packet_length != '0);

    pff_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dividend),
        .i_divisor  (step_v),
        .o_status   (div_st)
    );

    // fragment bookkeeping for the byte in r_byte
    always_comb begin
        first       = (r_taken == '0);
        flen_first  = (r_left < pff_pkg::LEN_W'(r_step)) ? r_left[pff_pkg::FSZ_W-1:0]
                                                          : r_step;
        slen_first  = pff_pkg::FBYTES_W'(flen_first)
                    + pff_pkg::FBYTES_W'(pff_pkg::pad_bytes(flen_first[1:0]))
                    + pff_pkg::TRAILER_BYTES;
        drop_frag_v = first ? (slen_first > pff_pkg::BUFFER_BYTES) : r_drop_frag;
        quiet       = r_drop_pkt || drop_frag_v;
        num_v       = first ? r_num + 8'd1 : r_num;
        asm_v       = first ? '0 : r_asm;
        lane_v      = first ? 2'd0 : r_lane;
        full        = (lane_v == 2'd3);
        taken_n     = r_taken + 1'b1;
        left_n      = r_left - 1'b1;
        frag_end    = (taken_n == r_step) || (left_n == '0);
        pad         = pff_pkg::pad_bytes(taken_n[1:0]);

        asm_ins = asm_v;
        case (lane_v)
            2'd0:    asm_ins[7:0]   = r_byte;
            2'd1:    asm_ins[15:8]  = r_byte;
            2'd2:    asm_ins[23:16] = r_byte;
            default: asm_ins        = asm_v;
        endcase
        asm_after  = full ? '0 : asm_ins;
        lane_after = full ? 2'd0 : lane_v + 2'd1;

        emit_w = !quiet && (full || (frag_end && (lane_after != 2'd0)));
        emit_t = !quiet && frag_end;
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_frag_size = r_frag_size;
        n_step      = r_step;
        n_left      = r_left;
        n_taken     = r_taken;
        n_num       = r_num;
        n_total     = r_total;
        n_asm       = r_asm;
        n_lane      = r_lane;
        n_drop_pkt  = r_drop_pkt;
        n_drop_frag = r_drop_frag;
        n_has_w     = r_has_w;
        n_has_t     = r_has_t;
        n_byte      = r_byte;
        n_pw        = r_pw;
        n_pt        = r_pt;
        n_pbytes    = r_pbytes;
        n_pdone     = r_pdone;
        n_ovalid    = r_ovalid && !i_ready;
        n_oword     = r_oword;
        n_otrl      = r_otrl;
        n_obytes    = r_obytes;
        n_odone     = r_odone;

        if (cfg_wr) begin
            n_frag_size = pwdata[pff_pkg::FSZ_W-1:0];
        end

        case (r_state)
            pff_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_byte = i_data_byte;
                    if (r_left != '0) begin
                        n_state = pff_pkg::S_PROC;
                    end else if (i_packet_length != '0) begin
                        // packet start
                        n_left  = i_packet_length;
                        n_step  = step_v;
                        n_num   = '0;
                        n_taken = '0;
                        n_asm   = '0;
                        n_lane  = '0;
                        n_state = pff_pkg::S_DIV;
                    end
                end
            end
            pff_pkg::S_DIV: begin
                if (div_st.done) begin
                    n_drop_pkt = (div_st.quotient[pff_pkg::DVD_W-1:8] != '0);
                    n_total    = n_drop_pkt ? 8'd0 : div_st.quotient[7:0];
                    n_state    = pff_pkg::S_PROC;
                end
            end
            pff_pkg::S_PROC: begin
                n_num       = num_v;
                n_drop_frag = drop_frag_v;
                n_left      = left_n;
                n_taken     = frag_end ? '0 : taken_n;
                n_asm       = frag_end ? '0 : asm_after;
                n_lane      = frag_end ? 2'd0 : lane_after;
                n_pw        = full ? {r_byte, asm_v} : {8'd0, asm_after};
                n_pt        = {6'd0, pad, r_total, num_v, 8'd0};
                n_pbytes    = pff_pkg::FBYTES_W'(taken_n) + pff_pkg::FBYTES_W'(pad)
                            + pff_pkg::TRAILER_BYTES;
                n_pdone     = (left_n == '0);
                n_has_w     = emit_w;
                n_has_t     = emit_t;
                n_state     = (emit_w || emit_t) ? pff_pkg::S_EMIT : pff_pkg::S_IDLE;
            end
            pff_pkg::S_EMIT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    if (r_has_w) begin
                        n_oword  = r_pw;
                        n_otrl   = 1'b0;
                        n_obytes = '0;
                        n_odone  = 1'b0;
                        n_has_w  = 1'b0;
                        if (!r_has_t) begin
                            n_state = pff_pkg::S_IDLE;
                        end
                    end else begin
                        n_oword  = r_pt;
                        n_otrl   = 1'b1;
                        n_obytes = r_pbytes;
                        n_odone  = r_pdone;
                        n_has_t  = 1'b0;
                        n_state  = pff_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = pff_pkg::S_IDLE;
            end
        endcase
    end

    // control and packet state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pff_pkg::S_IDLE;
            r_frag_size <= pff_pkg::FRAG_SIZE_RESET;
            r_step      <= '0;
            r_left      <= '0;
            r_taken     <= '0;
            r_num       <= '0;
            r_total     <= '0;
            r_asm       <= '0;
            r_lane      <= '0;
            r_drop_pkt  <= 1'b0;
            r_drop_frag <= 1'b0;
            r_has_w     <= 1'b0;
            r_has_t     <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_frag_size <= n_frag_size;
            r_step      <= n_step;
            r_left      <= n_left;
            r_taken     <= n_taken;
            r_num       <= n_num;
            r_total     <= n_total;
            r_asm       <= n_asm;
            r_lane      <= n_lane;
            r_drop_pkt  <= n_drop_pkt;
            r_drop_frag <= n_drop_frag;
            r_has_w     <= n_has_w;
            r_has_t     <= n_has_t;
            r_ovalid    <= n_ovalid;
        end
    end

    // byte and word payload
    always_ff @(posedge i_clk) begin
        r_byte   <= n_byte;
        r_pw     <= n_pw;
        r_pt     <= n_pt;
        r_pbytes <= n_pbytes;
        r_pdone  <= n_pdone;
        r_oword  <= n_oword;
        r_otrl   <= n_otrl;
        r_obytes <= n_obytes;
        r_odone  <= n_odone;
    end

    assign o_valid          = r_ovalid;
    assign o_out_word       = r_oword;
    assign o_is_trailer     = r_otrl;
    assign o_fragment_bytes = r_obytes;
    assign o_packet_done    = r_odone;

    assign prdata = {{(32 - pff_pkg::FSZ_W){1'b0}}, r_frag_size};
    assign pready = 1'b1;

endmodule

// File: rtl/pff_checker.sv
// port-level checks of the framer output channel, bound to the top level
// depends on packet_fragment_framer_core_assert.svh and pff_pkg
`timescale 1ns / 1ps
`include "packet_fragment_framer_core_assert.svh"

module pff_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_valid,
    input logic                           i_ready,
    input logic [pff_pkg::WORD_W-1:0]     o_out_word,
    input logic                           o_is_trailer,
    input logic [pff_pkg::FBYTES_W-1:0]   o_fragment_bytes,
    input logic                           o_packet_done
);

    // stalled word holds
    `PFF_ASSERT_NXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_out_word) && $stable(o_is_trailer))

    // data words carry no length and no done flag
    `PFF_ASSERT_IMP(a_data_side, i_clk, i_rst_n, o_valid && !o_is_trailer, (o_fragment_bytes == '0) && !o_packet_done)

    // trailer layout: byte 0 zero, pad below four, length word aligned and at least two words
    `PFF_ASSERT_IMP(a_trl_fmt, i_clk, i_rst_n, o_valid && o_is_trailer, (o_out_word[7:0] == 8'd0) && (o_out_word[31:26] == 6'd0) && (o_fragment_bytes[1:0] == 2'd0) && (o_fragment_bytes >= 12'd8))

    // fragment number counts from one up to the total, reaching it on the last
    `PFF_ASSERT_IMP(a_trl_num, i_clk, i_rst_n, o_valid && o_is_trailer, (o_out_word[15:8] != 8'd0) && (o_out_word[15:8] <= o_out_word[23:16]) && (!o_packet_done || (o_out_word[15:8] == o_out_word[23:16])))

endmodule

bind packet_fragment_framer_core pff_checker u_pff_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_out_word       (o_out_word),
    .o_is_trailer     (o_is_trailer),
    .o_fragment_bytes (o_fragment_bytes),
    .o_packet_done    (o_packet_done)
);
